@@ rtl/ocra_pkg.sv @@
// Shared types, widths and constants of the overlay comment row allocator.
package ocra_pkg;

    localparam int MODE_COUNT   = 4;
    localparam int START_W      = 32;
    localparam int DUR_W        = 20;
    localparam int HGT_W        = 12;
    localparam int LEN_W        = 16;
    localparam int MODE_W       = 2;
    localparam int POOL_W       = 2;
    localparam int ROW_W        = 11;
    localparam int SW_W         = 16;
    localparam int SH_W         = 11;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int STILL_TOL_MS = 100;
    localparam int TIME_W       = 1 + START_W + DUR_W;
    localparam int VALID_POS    = TIME_W - 1;

    localparam logic [SW_W-1:0] RST_STAGE_WIDTH  = SW_W'(1920);
    localparam logic [SH_W-1:0] RST_STAGE_HEIGHT = SH_W'(1080);
    localparam logic [SH_W-1:0] RST_RESERVED     = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCROLL_L = 2'd0,
        MODE_TOP      = 2'd1,
        MODE_BOTTOM   = 2'd2,
        MODE_SCROLL_R = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_STAGE_WIDTH  = 2'd0,
        REG_STAGE_HEIGHT = 2'd1,
        REG_RESERVED     = 2'd2,
        REG_DROP         = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        RES_PLACED = 2'd0,
        RES_OVER   = 2'd1,
        RES_DROP   = 2'd2
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN_ADDR,
        ST_SCAN_MUL,
        ST_SCAN_EVAL,
        ST_FB_ADDR,
        ST_FB_EVAL,
        ST_FB_DONE,
        ST_WIPE,
        ST_MARK_INIT,
        ST_MARK,
        ST_DONE_PLACED,
        ST_DONE_OVER,
        ST_DONE_DROP
    } state_t;

    typedef struct packed {
        logic [SW_W-1:0] stage_width;
        logic [SH_W-1:0] stage_height;
        logic [SH_W-1:0] reserved_bottom;
        logic            drop_when_full;
    } cfg_t;

    typedef struct packed {
        logic      load_item;
        logic      scan_start;
        logic      set_row_zero;
        logic      mul;
        logic      scan_step;
        logic      fb_start;
        logic      fb_step;
        logic      fb_commit;
        logic      wipe_start;
        logic      wipe_step;
        logic      mark_start;
        logic      mark_step;
        logic      clear_step;
        logic      out_load;
        res_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic oversize;
        logic ps_zero;
        logic found_now;
        logic scan_last;
        logic drop;
        logic fb_stop;
        logic best_zero;
        logic wipe_last;
        logic mark_more;
        logic out_free;
    } status_t;

endpackage

@@ rtl/ocra_comment_if.sv @@
// Channel carrying one comment beat into the allocator.
interface ocra_comment_if;
    logic                          valid;
    logic                          ready;
    logic [ocra_pkg::START_W-1:0]  start_ms;
    logic [ocra_pkg::DUR_W-1:0]    duration_ms;
    logic [ocra_pkg::HGT_W-1:0]    block_height;
    logic [ocra_pkg::LEN_W-1:0]    block_length;
    logic [ocra_pkg::MODE_W-1:0]   mode;
    logic [ocra_pkg::POOL_W-1:0]   pool;

    modport source (output valid, start_ms, duration_ms, block_height, block_length, mode,
                    pool, input ready);
    modport sink (input valid, start_ms, duration_ms, block_height, block_length, mode,
                  pool, output ready);
endinterface

@@ rtl/ocra_place_if.sv @@
// Channel carrying one placement result beat out of the allocator.
interface ocra_place_if;
    logic                        valid;
    logic                        ready;
    logic [ocra_pkg::ROW_W-1:0]  row;
    logic                        centre_align;
    logic                        placed;

    modport source (output valid, row, centre_align, placed, input ready);
    modport sink (input valid, row, centre_align, placed, output ready);
endinterface

@@ rtl/ocra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ocra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ocra_regs.sv @@
// APB-style configuration registers of the allocator.
module ocra_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  reg_sel,
    input  logic [ocra_pkg::APB_DW-1:0] pwdata,
    output logic [ocra_pkg::APB_DW-1:0] prdata,
    output ocra_pkg::cfg_t              cfg
);

    ocra_pkg::cfg_t cfg_reg;
    ocra_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (ocra_pkg::reg_idx_t'(reg_sel))
                ocra_pkg::REG_STAGE_WIDTH:  cfg_next.stage_width = pwdata[ocra_pkg::SW_W-1:0];
                ocra_pkg::REG_STAGE_HEIGHT: cfg_next.stage_height = pwdata[ocra_pkg::SH_W-1:0];
                ocra_pkg::REG_RESERVED:  cfg_next.reserved_bottom = pwdata[ocra_pkg::SH_W-1:0];
                ocra_pkg::REG_DROP:         cfg_next.drop_when_full = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stage_width     <= ocra_pkg::RST_STAGE_WIDTH;
            cfg_reg.stage_height    <= ocra_pkg::RST_STAGE_HEIGHT;
            cfg_reg.reserved_bottom <= ocra_pkg::RST_RESERVED;
            cfg_reg.drop_when_full  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (ocra_pkg::reg_idx_t'(reg_sel))
            ocra_pkg::REG_STAGE_WIDTH:  prdata = ocra_pkg::APB_DW'(cfg_reg.stage_width);
            ocra_pkg::REG_STAGE_HEIGHT: prdata = ocra_pkg::APB_DW'(cfg_reg.stage_height);
            ocra_pkg::REG_RESERVED:     prdata = ocra_pkg::APB_DW'(cfg_reg.reserved_bottom);
            ocra_pkg::REG_DROP:         prdata = ocra_pkg::APB_DW'(cfg_reg.drop_when_full);
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ocra_ctrl.sv @@
// Sequencer that walks one comment through search, fallback, wipe and marking.
module ocra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ocra_pkg::status_t  status,
    output ocra_pkg::cmd_t     cmd
);

    ocra_pkg::state_t state_reg;
    ocra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ocra_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ocra_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ocra_pkg::ST_IDLE;
                end
            end
            ocra_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ocra_pkg::ST_SETUP;
                end
            end
            ocra_pkg::ST_SETUP:
            begin
                if (status.oversize)
                begin
                    state_next = ocra_pkg::ST_DONE_OVER;
                end
                else if (status.ps_zero)
                begin
                    state_next = ocra_pkg::ST_DONE_PLACED;
                end
                else
                begin
                    state_next = ocra_pkg::ST_SCAN_ADDR;
                end
            end
            ocra_pkg::ST_SCAN_ADDR: state_next = ocra_pkg::ST_SCAN_MUL;
            ocra_pkg::ST_SCAN_MUL:  state_next = ocra_pkg::ST_SCAN_EVAL;
            ocra_pkg::ST_SCAN_EVAL:
            begin
                if (status.found_now)
                begin
                    state_next = ocra_pkg::ST_MARK_INIT;
                end
                else if (status.scan_last)
                begin
                    state_next = status.drop ? ocra_pkg::ST_DONE_DROP : ocra_pkg::ST_FB_ADDR;
                end
                else
                begin
                    state_next = ocra_pkg::ST_SCAN_ADDR;
                end
            end
            ocra_pkg::ST_FB_ADDR: state_next = ocra_pkg::ST_FB_EVAL;
            ocra_pkg::ST_FB_EVAL:
            begin
                state_next = status.fb_stop ? ocra_pkg::ST_FB_DONE : ocra_pkg::ST_FB_ADDR;
            end
            ocra_pkg::ST_FB_DONE:
            begin
                state_next = status.best_zero ? ocra_pkg::ST_WIPE : ocra_pkg::ST_MARK_INIT;
            end
            ocra_pkg::ST_WIPE:
            begin
                if (status.wipe_last)
                begin
                    state_next = ocra_pkg::ST_MARK_INIT;
                end
            end
            ocra_pkg::ST_MARK_INIT: state_next = ocra_pkg::ST_MARK;
            ocra_pkg::ST_MARK:
            begin
                if (!status.mark_more)
                begin
                    state_next = ocra_pkg::ST_DONE_PLACED;
                end
            end
            ocra_pkg::ST_DONE_PLACED, ocra_pkg::ST_DONE_OVER, ocra_pkg::ST_DONE_DROP:
            begin
                if (status.out_free)
                begin
                    state_next = ocra_pkg::ST_IDLE;
                end
            end
            default: state_next = ocra_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = ocra_pkg::RES_PLACED;
        in_ready     = 1'b0;
        case (state_reg)
            ocra_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            ocra_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ocra_pkg::ST_SETUP:
            begin
                cmd.set_row_zero = status.ps_zero;
                cmd.scan_start   = !status.oversize && !status.ps_zero;
            end
            ocra_pkg::ST_SCAN_ADDR: cmd = cmd;
            ocra_pkg::ST_SCAN_MUL:  cmd.mul = 1'b1;
            ocra_pkg::ST_SCAN_EVAL:
            begin
                cmd.scan_step = 1'b1;
                cmd.fb_start  = !status.found_now && status.scan_last && !status.drop;
            end
            ocra_pkg::ST_FB_ADDR: cmd = cmd;
            ocra_pkg::ST_FB_EVAL: cmd.fb_step = 1'b1;
            ocra_pkg::ST_FB_DONE:
            begin
                cmd.fb_commit  = 1'b1;
                cmd.wipe_start = status.best_zero;
            end
            ocra_pkg::ST_WIPE:      cmd.wipe_step = 1'b1;
            ocra_pkg::ST_MARK_INIT: cmd.mark_start = 1'b1;
            ocra_pkg::ST_MARK:      cmd.mark_step = status.mark_more;
            ocra_pkg::ST_DONE_PLACED:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = ocra_pkg::RES_PLACED;
            end
            ocra_pkg::ST_DONE_OVER:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = ocra_pkg::RES_OVER;
            end
            ocra_pkg::ST_DONE_DROP:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = ocra_pkg::RES_DROP;
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ rtl/ocra_dp.sv @@
// Datapath: row map memories, collision arithmetic, row counters and result register.
module ocra_dp #(
    parameter int ROW_DEPTH  = 2048,
    parameter int POOL_COUNT = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ocra_pkg::cfg_t                cfg,
    input  ocra_pkg::cmd_t                cmd,
    output ocra_pkg::status_t             status,
    input  logic [ocra_pkg::START_W-1:0]  in_start_ms,
    input  logic [ocra_pkg::DUR_W-1:0]    in_duration_ms,
    input  logic [ocra_pkg::HGT_W-1:0]    in_block_height,
    input  logic [ocra_pkg::LEN_W-1:0]    in_block_length,
    input  logic [ocra_pkg::MODE_W-1:0]   in_mode,
    input  logic [ocra_pkg::POOL_W-1:0]   in_pool,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ocra_pkg::ROW_W-1:0]    out_row,
    output logic                          out_centre_align,
    output logic                          out_placed
);

    localparam int ROW_CNT_W = $clog2(ROW_DEPTH + 1);
    localparam int ROW_AW    = $clog2(ROW_DEPTH);
    localparam int MAP_COUNT = POOL_COUNT * ocra_pkg::MODE_COUNT;
    localparam int MAP_W     = $clog2(MAP_COUNT);
    localparam int MEM_DEPTH = MAP_COUNT * ROW_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int XW        = ((ROW_CNT_W > ocra_pkg::HGT_W) ? ROW_CNT_W : ocra_pkg::HGT_W) + 2;
    localparam int LW        = ocra_pkg::LEN_W + 1;
    localparam int PW        = ocra_pkg::START_W + 1 + LW + 1;

    // Item registers.
    logic [ocra_pkg::START_W-1:0] start_reg;
    logic [ocra_pkg::DUR_W-1:0]   dur_reg;
    logic [ocra_pkg::HGT_W-1:0]   ps_reg;
    logic [ocra_pkg::LEN_W-1:0]   len_reg;
    logic                         still_reg;
    logic [MEM_AW-1:0]            base_reg;
    logic [ROW_CNT_W-1:0]         u_reg;
    logic [LW-1:0]                d_reg;
    logic [ocra_pkg::LEN_W-1:0]   n_reg;

    // Walk registers.
    logic [ROW_CNT_W-1:0]         idx_reg;
    logic [ROW_CNT_W-1:0]         cnt_reg;
    logic [ROW_CNT_W-1:0]         best_row_reg;
    logic [ocra_pkg::START_W-1:0] best_start_reg;
    logic [ROW_CNT_W-1:0]         res_row_reg;
    logic [MEM_AW-1:0]            clr_reg;

    // Collision product registers.
    logic signed [PW-1:0]         p1_reg;
    logic [ocra_pkg::DUR_W+ocra_pkg::LEN_W-1:0] p2_reg;
    logic signed [PW-1:0]         p3_reg;
    logic [ocra_pkg::DUR_W+ocra_pkg::LEN_W-1:0] p4_reg;
    logic                         occ_valid_reg;
    logic                         still_hit_reg;
    logic                         olw_zero_reg;

    // Result register.
    logic                         out_valid_reg;
    logic [ocra_pkg::ROW_W-1:0]   out_row_reg;
    logic                         out_centre_reg;
    logic                         out_placed_reg;

    // Memory ports.
    logic                         mem_we;
    logic [MEM_AW-1:0]            mem_waddr;
    logic [MEM_AW-1:0]            mem_raddr;
    logic [ocra_pkg::TIME_W-1:0]  time_wdata;
    logic [ocra_pkg::TIME_W-1:0]  time_rdata;
    logic [ocra_pkg::LEN_W-1:0]   len_wdata;
    logic [ocra_pkg::LEN_W-1:0]   len_rdata;

    // Load-time decode.
    logic [ocra_pkg::POOL_W-1:0]  pool_c;
    logic [MAP_W-1:0]             map_idx;
    logic signed [ocra_pkg::SH_W+1:0] h_diff;
    logic [ROW_CNT_W-1:0]         u_calc;
    logic [LW-1:0]                lw_sum;

    // Memory read decode.
    logic                         occ_valid;
    logic [ocra_pkg::START_W-1:0] occ_start;
    logic [ocra_pkg::DUR_W-1:0]   occ_dur;
    logic signed [ocra_pkg::START_W:0] dp_s;
    logic [LW-1:0]                olw;
    logic [ocra_pkg::START_W:0]   still_sum;
    logic [ocra_pkg::START_W:0]   still_lim;

    // Evaluation.
    logic signed [PW:0]           s1;
    logic signed [PW:0]           s2;
    logic                         hit;
    logic [XW-1:0]                idx_x;
    logic [XW-1:0]                u_x;
    logic [XW-1:0]                ps_x;
    logic [XW-1:0]                rmax_x;
    logic [XW-1:0]                end_x;

    assign pool_c = ({1'b0, in_pool} >= (ocra_pkg::POOL_W + 1)'(POOL_COUNT))
                    ? ocra_pkg::POOL_W'(POOL_COUNT - 1) : in_pool;
    assign map_idx = MAP_W'({pool_c, in_mode});
    assign h_diff  = $signed({2'b00, cfg.stage_height}) - $signed({2'b00, cfg.reserved_bottom});
    assign lw_sum  = LW'(in_block_length) + LW'(cfg.stage_width);

    always_comb
    begin
        if (h_diff < 0)
        begin
            u_calc = '0;
        end
        else if (XW'(h_diff[ocra_pkg::SH_W-1:0]) > XW'(ROW_DEPTH))
        begin
            u_calc = ROW_CNT_W'(ROW_DEPTH);
        end
        else
        begin
            u_calc = ROW_CNT_W'(h_diff[ocra_pkg::SH_W-1:0]);
        end
    end

    assign occ_valid = time_rdata[ocra_pkg::VALID_POS];
    assign occ_start = time_rdata[ocra_pkg::START_W+ocra_pkg::DUR_W-1:ocra_pkg::DUR_W];
    assign occ_dur   = time_rdata[ocra_pkg::DUR_W-1:0];
    assign dp_s      = $signed({1'b0, occ_start}) - $signed({1'b0, start_reg});
    assign olw       = LW'(len_rdata) + LW'(cfg.stage_width);
    assign still_sum = (ocra_pkg::START_W + 1)'(occ_start) + (ocra_pkg::START_W + 1)'(occ_dur);
    assign still_lim = (ocra_pkg::START_W + 1)'(start_reg)
                       + (ocra_pkg::START_W + 1)'(ocra_pkg::STILL_TOL_MS);

    assign s1  = $signed({p1_reg[PW-1], p1_reg}) + $signed((PW + 1)'(p2_reg));
    assign s2  = $signed({p3_reg[PW-1], p3_reg}) + $signed((PW + 1)'(p4_reg));
    assign hit = occ_valid_reg && (still_reg ? still_hit_reg
                 : (!olw_zero_reg && ((s1 > 0) || (s2 > 0))));

    assign idx_x  = XW'(idx_reg);
    assign u_x    = XW'(u_reg);
    assign ps_x   = XW'(ps_reg);
    assign rmax_x = u_x - ps_x;
    assign end_x  = XW'(res_row_reg) + ps_x;

    always_comb
    begin
        status.clear_last = (clr_reg == MEM_AW'(MEM_DEPTH - 1));
        status.oversize   = (ps_x >= u_x);
        status.ps_zero    = (ps_reg == '0);
        status.found_now  = !hit && ((XW'(cnt_reg) + XW'(1)) == ps_x);
        status.scan_last  = ((idx_x + XW'(1)) == u_x);
        status.drop       = cfg.drop_when_full;
        status.fb_stop    = !occ_valid || ((idx_x + XW'(1)) == rmax_x);
        status.best_zero  = (best_row_reg == '0);
        status.wipe_last  = (idx_x == XW'(ROW_DEPTH - 1));
        status.mark_more  = (idx_x < end_x) && (idx_x <= u_x) && (idx_x < XW'(ROW_DEPTH));
        status.out_free   = !out_valid_reg || out_ready;
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            start_reg <= in_start_ms;
            dur_reg   <= in_duration_ms;
            ps_reg    <= in_block_height;
            len_reg   <= in_block_length;
            still_reg <= (in_mode == ocra_pkg::MODE_TOP) || (in_mode == ocra_pkg::MODE_BOTTOM);
            base_reg  <= MEM_AW'(map_idx) * MEM_AW'(ROW_DEPTH);
            u_reg     <= u_calc;
            if (lw_sum == '0)
            begin
                d_reg <= LW'(1);
                n_reg <= ocra_pkg::LEN_W'(1);
            end
            else
            begin
                d_reg <= lw_sum;
                n_reg <= in_block_length;
            end
        end
    end

    // Products of the scrolling catch-up tests, one row per pass.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p1_reg        <= dp_s * $signed({1'b0, d_reg});
            p2_reg        <= dur_reg * n_reg;
            p3_reg        <= dp_s * $signed({1'b0, olw});
            p4_reg        <= len_rdata * occ_dur;
            occ_valid_reg <= occ_valid;
            still_hit_reg <= still_sum > still_lim;
            olw_zero_reg  <= (olw == '0);
        end
    end

    // Row walk counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            cnt_reg      <= '0;
            best_row_reg <= '0;
            res_row_reg  <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + MEM_AW'(1);
            end
            if (cmd.set_row_zero)
            begin
                res_row_reg <= '0;
            end
            // The fallback row is taken even when the wipe starts in the same cycle.
            if (cmd.fb_commit)
            begin
                res_row_reg <= best_row_reg;
            end
            if (cmd.scan_start || cmd.fb_start || cmd.wipe_start)
            begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + ROW_CNT_W'(1);
                cnt_reg <= hit ? '0 : cnt_reg + ROW_CNT_W'(1);
                if (status.found_now)
                begin
                    res_row_reg <= ROW_CNT_W'(idx_x + XW'(1) - ps_x);
                end
            end
            else if (cmd.fb_step)
            begin
                idx_reg <= idx_reg + ROW_CNT_W'(1);
                if (!occ_valid || (idx_reg == '0) || (occ_start < best_start_reg))
                begin
                    best_row_reg <= idx_reg;
                end
            end
            else if (cmd.wipe_step || cmd.mark_step)
            begin
                idx_reg <= idx_reg + ROW_CNT_W'(1);
            end
            else if (cmd.mark_start)
            begin
                idx_reg <= res_row_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fb_step && occ_valid && ((idx_reg == '0) || (occ_start < best_start_reg)))
        begin
            best_start_reg <= occ_start;
        end
    end

    // Memory access.
    assign mem_raddr  = base_reg + MEM_AW'(idx_reg[ROW_AW-1:0]);
    assign mem_we     = cmd.clear_step || cmd.wipe_step || cmd.mark_step;
    assign mem_waddr  = cmd.clear_step ? clr_reg : mem_raddr;
    assign time_wdata = cmd.mark_step ? {1'b1, start_reg, dur_reg} : '0;
    assign len_wdata  = cmd.mark_step ? len_reg : '0;

    ocra_ram #(
        .WIDTH (ocra_pkg::TIME_W),
        .DEPTH (MEM_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (time_wdata),
        .raddr (mem_raddr),
        .rdata (time_rdata)
    );

    ocra_ram #(
        .WIDTH (ocra_pkg::LEN_W),
        .DEPTH (MEM_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (len_wdata),
        .raddr (mem_raddr),
        .rdata (len_rdata)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                ocra_pkg::RES_OVER:
                begin
                    out_row_reg    <= still_reg ? '0 : ocra_pkg::ROW_W'(u_reg >> 1);
                    out_centre_reg <= !still_reg;
                    out_placed_reg <= 1'b1;
                end
                ocra_pkg::RES_DROP:
                begin
                    out_row_reg    <= '0;
                    out_centre_reg <= 1'b0;
                    out_placed_reg <= 1'b0;
                end
                default:
                begin
                    out_row_reg    <= ocra_pkg::ROW_W'(res_row_reg);
                    out_centre_reg <= 1'b0;
                    out_placed_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_row          = out_row_reg;
    assign out_centre_align = out_centre_reg;
    assign out_placed       = out_placed_reg;

endmodule

@@ rtl/overlay_comment_row_allocator.sv @@
// Top level of the overlay comment row allocator.
// After a beat is taken: a setup state, a search that reads rows up to the usable height U
// through SCAN_ADDR, SCAN_MUL and SCAN_EVAL, a fallback walk through FB_ADDR and FB_EVAL
// ending in FB_DONE if the search fails with drop mode off, a wipe of all ROW_DEPTH rows of
// the map when the fallback lands on row 0, marking of the block_height rows, and the load of
// the result register. One comment is in work at a time. Reset: the map is cleared one entry
// a cycle, all POOL_COUNT*4*ROW_DEPTH entries (24576 by default), before the first beat is taken.
module overlay_comment_row_allocator #(
    parameter int ROW_DEPTH  = 2048,
    parameter int POOL_COUNT = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ocra_comment_if.sink                comment,
    ocra_place_if.source                placement,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ocra_pkg::APB_AW-1:0] paddr,
    input  logic [ocra_pkg::APB_DW-1:0] pwdata,
    output logic [ocra_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    ocra_pkg::cfg_t    cfg;
    ocra_pkg::cmd_t    cmd;
    ocra_pkg::status_t status;
    logic              in_ready;

    // Registers are word aligned, so the word index is the upper address bits.
    ocra_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .reg_sel (paddr[3:2]),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // The sequencer owns the handshake on the input side; the datapath owns the result
    // register, which lets a finished result wait while the next comment is taken.
    ocra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (comment.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign comment.ready = in_ready;

    ocra_dp #(
        .ROW_DEPTH  (ROW_DEPTH),
        .POOL_COUNT (POOL_COUNT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .in_start_ms      (comment.start_ms),
        .in_duration_ms   (comment.duration_ms),
        .in_block_height  (comment.block_height),
        .in_block_length  (comment.block_length),
        .in_mode          (comment.mode),
        .in_pool          (comment.pool),
        .out_ready        (placement.ready),
        .out_valid        (placement.valid),
        .out_row          (placement.row),
        .out_centre_align (placement.centre_align),
        .out_placed       (placement.placed)
    );

    // Only one comment is in work at a time: a taken beat closes the input at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (comment.valid && comment.ready) |=> !comment.ready)
        else $error("comment beat taken while another is in work");

    // A dropped result can only come out in drop mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (placement.valid && !placement.placed) |-> cfg.drop_when_full)
        else $error("comment dropped with drop mode off");

    // Centre alignment only goes with a placed oversized comment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (placement.valid && placement.centre_align) |-> placement.placed)
        else $error("centre alignment on a dropped comment");

    // The row map is never written while a new comment can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mark_step || cmd.wipe_step || cmd.clear_step) |-> !comment.ready)
        else $error("row map written while idle");

endmodule
